// ===== rtl/ped_pkg.sv =====
// shared types, constants and helpers for the percent-escape decoder
package ped_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  // one input byte's worth of output: up to three bytes, with a count
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       fin;
  } ped_job_t;

  // hex digit decode: bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// ===== rtl/ped_front.sv =====
// front end: escape tracking and expansion of each input byte into a job
module ped_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       in_byte,
  input  logic             in_final,
  input  logic             accept,
  output ped_pkg::ped_job_t job,
  output logic             job_push
);
  import ped_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held_digit_char, held_next;
  logic [4:0] in_hex, held_hex;
  logic       is_open;

  assign in_hex   = hex_decode(in_byte);
  assign held_hex = hex_decode(held_digit_char);
  // a '%' that is not the last byte starts a new escape
  assign is_open  = (in_byte == PCT_CHAR) && !in_final;

  always_comb begin
    job        = '0;
    job.fin    = in_final;
    phase_next = PH_IDLE;
    held_next  = held_digit_char;
    case (phase)
      PH_PCT: begin
        if (!in_hex[4] && !in_final) begin
          held_next  = in_byte;
          phase_next = PH_DIGIT;
        end else begin
          job.b0 = PCT_CHAR;
          if (is_open) begin
            job.cnt    = 2'd1;
            phase_next = PH_PCT;
          end else begin
            job.b1  = in_byte;
            job.cnt = 2'd2;
          end
        end
      end
      PH_DIGIT: begin
        if (!in_hex[4]) begin
          job.b0  = {held_hex[3:0], in_hex[3:0]};
          job.cnt = 2'd1;
        end else begin
          job.b0 = PCT_CHAR;
          job.b1 = held_digit_char;
          if (is_open) begin
            job.cnt    = 2'd2;
            phase_next = PH_PCT;
          end else begin
            job.b2  = in_byte;
            job.cnt = 2'd3;
          end
        end
      end
      default: begin
        if (is_open) begin
          phase_next = PH_PCT;
        end else begin
          job.b0  = in_byte;
          job.cnt = 2'd1;
        end
      end
    endcase
    if (in_final) phase_next = PH_IDLE;
  end

  assign job_push = accept && (job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_digit_char <= held_next;
    end
  end

endmodule

// ===== rtl/ped_queue.sv =====
// short job queue between the front and back ends
module ped_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ped_pkg::ped_job_t push_job,
  input  logic              pop,
  output ped_pkg::ped_job_t head,
  output logic              empty,
  output logic              full
);
  import ped_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ped_job_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/ped_back.sv =====
// back end: sends the bytes of the head job one request at a time
module ped_back (
  input  logic              clk,
  input  logic              rst,
  input  ped_pkg::ped_job_t head,
  input  logic              empty,
  output logic              pop,
  output logic [7:0]        out_byte,
  output logic              run_end,
  output logic              string_end,
  output logic              out_valid,
  input  logic              out_ready
);
  import ped_pkg::*;

  logic [1:0] idx;
  logic       send;

  assign out_valid  = !empty;
  assign send       = out_valid && out_ready;
  assign run_end    = (idx == head.cnt - 2'd1);
  assign string_end = run_end && head.fin;
  assign pop        = send && run_end;

  always_comb begin
    case (idx)
      2'd0:    out_byte = head.b0;
      2'd1:    out_byte = head.b1;
      default: out_byte = head.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (send) begin
      idx <= run_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== rtl/percent_escape_decoder.sv =====
// top level of the percent-escape decoder
//
// Input channel (in_valid/in_ready) takes one raw byte per request, with
// in_final set on the last byte of a string. '%' plus two hex digits is
// decoded to one byte; anything else, including a broken or cut-short
// escape, comes out literally. Output channel (out_valid/out_ready) gives
// one byte per request with run_end on the last byte caused by an input
// and string_end on the last byte of the string.
// Throughput: one input per cycle while out_ready stays high and each input
// yields one byte; an input that yields two or three bytes takes that many
// output requests, and a '%' or first digit yields none. The output port is fed
// from a job queue of QUEUE_DEPTH entries, so a byte accepted into the queue
// can be shown from the next cycle.
// When out_ready is low the queue fills and in_ready drops once it is full;
// the escape state only advances on accepted inputs.
// Reset (rst, synchronous) empties the queue and clears any pending escape.
module percent_escape_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_end,
  output logic       out_valid,
  input  logic       out_ready
);
  import ped_pkg::*;

  ped_job_t job, head;
  logic     job_push, pop, empty, full, accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  ped_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (in_byte),
    .in_final (in_final),
    .accept   (accept),
    .job      (job),
    .job_push (job_push)
  );

  ped_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  ped_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

// ===== rtl/ped_checker.sv =====
// port-level checks for the percent-escape decoder, bound to the top level
module ped_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       string_end,
  input logic       out_valid,
  input logic       out_ready
);

  // string end is always also the end of a run
  a_string_end_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_end)
    else $error("string_end without run_end");

  // queue comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not empty after reset");

  // a stalled output holds its request
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(run_end) && $stable(string_end))
    else $error("output request changed while stalled");

  // input is refused only while output is backed up
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with nothing to send");

endmodule

bind percent_escape_decoder ped_checker u_ped_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_byte   (out_byte),
  .run_end    (run_end),
  .string_end (string_end),
  .out_valid  (out_valid),
  .out_ready  (out_ready)
);

// ===== sim/tb.sv =====
// testbench for the percent-escape decoder: scoreboard, stimulus and checks
`timescale 1ns / 1ps

class escape_scoreboard;
  typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT} esc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_last;
  } out_rec_t;

  out_rec_t   expected_q[$];
  out_rec_t   run_q[$];
  esc_phase_t phase;
  logic [7:0] held_digit;
  int         errors;
  int         requests;
  int         strings;
  int         results;
  int         decoded;
  int         literal_runs;

  function new();
    phase        = ESC_NONE;
    held_digit   = 8'h00;
    errors       = 0;
    requests     = 0;
    strings      = 0;
    results      = 0;
    decoded      = 0;
    literal_runs = 0;
  endfunction

  // 0..15 for a hex digit of either case, 16 for anything else
  function int digit_of(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
    return 16;
  endfunction

  function void emit(logic [7:0] b);
    out_rec_t r;
    r.data     = b;
    r.run_last = 1'b0;
    r.str_last = 1'b0;
    run_q.insert(run_q.size(), r);
  endfunction

  // byte seen with nothing pending; a non-final '%' opens an escape
  function void take_plain(logic [7:0] b, logic fin);
    if (b == ped_pkg::PCT_CHAR && !fin) begin
      phase = ESC_PCT;
    end else begin
      emit(b);
      phase = ESC_NONE;
    end
  endfunction

  function void note_request(logic [7:0] b, logic fin);
    int v;
    int hi;
    v = digit_of(b);
    run_q.delete();
    requests++;
    if (fin) strings++;
    case (phase)
      ESC_PCT: begin
        if (v < 16 && !fin) begin
          held_digit = b;
          phase = ESC_DIGIT;
        end else begin
          emit(ped_pkg::PCT_CHAR);
          literal_runs++;
          take_plain(b, fin);
        end
      end
      ESC_DIGIT: begin
        if (v < 16) begin
          hi = digit_of(held_digit);
          emit(8'(hi * 16 + v));
          decoded++;
          phase = ESC_NONE;
        end else begin
          emit(ped_pkg::PCT_CHAR);
          emit(held_digit);
          literal_runs++;
          take_plain(b, fin);
        end
      end
      default: begin
        take_plain(b, fin);
      end
    endcase
    if (fin) phase = ESC_NONE;
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].run_last = 1'b1;
      run_q[run_q.size() - 1].str_last = fin;
    end
    foreach (run_q[i]) expected_q.insert(expected_q.size(), run_q[i]);
  endfunction

  function void check_result(logic [7:0] b, logic re, logic se);
    out_rec_t exp_rec;
    results++;
    if (expected_q.size() == 0) begin
      $error("unexpected output byte %h (run_end %b, string_end %b)", b, re, se);
      errors++;
      return;
    end
    exp_rec = expected_q.pop_front();
    if (b !== exp_rec.data) begin
      $error("out_byte: expected %h, got %h", exp_rec.data, b);
      errors++;
    end
    if (re !== exp_rec.run_last) begin
      $error("run_end: expected %b, got %b", exp_rec.run_last, re);
      errors++;
    end
    if (se !== exp_rec.str_last) begin
      $error("string_end: expected %b, got %b", exp_rec.str_last, se);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int LONG_HOLD      = 300;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic [7:0] in_byte    = 8'h00;
  logic       in_final   = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;
  logic       out_valid;
  logic       out_ready  = 1'b0;

  escape_scoreboard sb;
  bit no_idle_in  = 1'b0;
  bit no_idle_out = 1'b0;
  int hold_len    = 0;
  int idle_cycles = 0;

  percent_escape_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .in_final   (in_final),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1) == 1) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 10);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic f);
    int gap;
    gap = no_idle_in ? 0 : draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_final <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  // mostly well-formed escapes, with plain bytes and broken escapes mixed in
  task automatic send_random_string(output int n);
    logic [7:0] str_q[$];
    int         kind;
    int         tokens;
    tokens = $urandom_range(1, 6);
    for (int t = 0; t < tokens; t++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        str_q.insert(str_q.size(), ped_pkg::PCT_CHAR);
        str_q.insert(str_q.size(), rand_hex_char());
        str_q.insert(str_q.size(), rand_hex_char());
      end else if (kind < 9) begin
        str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
      end else begin
        str_q.insert(str_q.size(), ped_pkg::PCT_CHAR);
        if ($urandom_range(0, 1) == 1) str_q.insert(str_q.size(), rand_hex_char());
      end
    end
    foreach (str_q[i]) send_item(str_q[i], i == str_q.size() - 1);
    n = str_q.size();
  endtask

  task automatic send_random_phase(input int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      send_random_string(n);
      sent += n;
    end
  endtask

  // drop the request line, then wait for every expected byte
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // receiver: per-request back-pressure, plus the occasional long hold-off
  initial begin
    int gap;
    int n;
    @(negedge rst);
    forever begin
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      gap = no_idle_out ? 0 : draw_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(in_byte, in_final);
      if (out_valid && out_ready) sb.check_result(out_byte, run_end, string_end);
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: both cases of digits, decoded extremes, cut-short and broken escapes
    send_string("%41");
    send_string("%6a%Ff");
    send_string("%00");
    send_string("%");
    send_string("%4");
    send_string("%4z");
    send_string("%4%");
    send_string("%%");
    send_string("%%41");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    wait_drained();

    send_random_phase(90);
    wait_drained();

    // receiver holds off while the sender floods, so the block backs up
    hold_len   = LONG_HOLD;
    no_idle_in = 1'b1;
    send_random_phase(40);
    no_idle_in = 1'b0;

    no_idle_in  = 1'b1;
    no_idle_out = 1'b1;
    send_random_phase(80);
    no_idle_in  = 1'b0;
    no_idle_out = 1'b0;
    wait_drained();

    send_random_phase(90);
    wait_drained();

    $display("run covered %0d input bytes in %0d strings, %0d output bytes checked",
             sb.requests, sb.strings, sb.results);
    $display("  %0d escapes decoded, %0d escapes emitted literally",
             sb.decoded, sb.literal_runs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
